>>> rtl/flp_pkg.sv
// shared types and constants for the fibonacci lattice point generator
`timescale 1ns / 1ps

package flp_pkg;

  localparam int unsigned IdxW    = 6;
  localparam int unsigned WordW   = 32;
  localparam logic [IdxW-1:0] IdxMin = 6'd3;
  localparam logic [IdxW-1:0] IdxMax = 6'd47;
  localparam logic [WordW-1:0] FibSeed = 32'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIB,
    ST_XGO,
    ST_XWAIT,
    ST_YGO,
    ST_YWAIT,
    ST_OUT
  } flp_state_e;

  typedef struct packed {
    logic fib_load;
    logic fib_step;
    logic seq_init;
    logic div_start;
    logic div_sel_y;
    logic x_store;
    logic y_store;
    logic out_load;
  } flp_cmd_t;

  typedef struct packed {
    logic need_fib;
    logic fib_done;
    logic div_done;
    logic out_free;
  } flp_sts_t;

endpackage

>>> rtl/flp_div.sv
// restoring radix-2 divider for fractions num/den with num below den
`timescale 1ns / 1ps

module flp_div import flp_pkg::*; #(
  parameter int unsigned FracBits = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WordW-1:0]    num_i,
  input  logic [WordW-1:0]    den_i,
  output logic                done_o,
  output logic [FracBits-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(FracBits + 1);

  logic [WordW-1:0]    rem_q, rem_d;
  logic [WordW-1:0]    den_q, den_d;
  logic [FracBits-1:0] quo_q, quo_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [WordW:0]      shifted;
  logic [WordW:0]      diff;
  logic                fits;

  assign shifted = {rem_q, 1'b0};
  assign diff    = shifted - {1'b0, den_q};
  assign fits    = shifted >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i;
      den_d  = den_i;
      quo_d  = '0;
      cnt_d  = CntW'(FracBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[WordW-1:0] : shifted[WordW-1:0];
      quo_d = {quo_q[FracBits-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  a_no_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < den_q) else $error("divider remainder out of range");
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q) else $error("divider done without run");

endmodule

>>> rtl/flp_dpath.sv
// datapath: index register, fibonacci recurrence, point state, divider, output register
`timescale 1ns / 1ps

module flp_dpath import flp_pkg::*; #(
  parameter int unsigned FracBits = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [IdxW-1:0]     cfg_wdata_i,
  input  logic                restart_i,
  input  flp_cmd_t            cmd_i,
  output flp_sts_t            sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [5*WordW-1:0]  out_data_o,
  output logic                out_last_o
);

  logic [IdxW-1:0]  idx_q;
  logic [IdxW-1:0]  idx_clamped;
  logic [IdxW-1:0]  cnt_q;
  logic [WordW-1:0] fa_q, fb_q, fc_q;
  logic [WordW-1:0] k_q, res_q;
  logic             ready_q;
  logic [WordW-1:0] x_q, y_q;
  logic             out_valid_q;
  logic [5*WordW-1:0] out_data_q;
  logic             out_last_q;
  logic             is_last;
  logic [WordW:0]   res_sum;
  logic [WordW-1:0] res_next;
  logic             div_done;
  logic [FracBits-1:0] quo;

  always_comb begin
    idx_clamped = idx_q;
    if (idx_q < IdxMin) idx_clamped = IdxMin;
    if (idx_q > IdxMax) idx_clamped = IdxMax;
  end

  assign is_last  = (k_q == fc_q - 1'b1);
  assign res_sum  = {1'b0, res_q} + {1'b0, fa_q};
  assign res_next = (res_sum >= {1'b0, fc_q}) ? WordW'(res_sum - {1'b0, fc_q})
                                              : res_sum[WordW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= IdxMin;
    end else if (cfg_we_i) begin
      idx_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      fa_q    <= '0;
      fb_q    <= '0;
      fc_q    <= '0;
      k_q     <= '0;
      res_q   <= '0;
      ready_q <= 1'b0;
    end else begin
      if (cmd_i.fib_load) begin
        fa_q  <= FibSeed;
        fb_q  <= FibSeed;
        fc_q  <= FibSeed + FibSeed;
        cnt_q <= idx_clamped - IdxMin;
      end else if (cmd_i.fib_step) begin
        fa_q  <= fb_q;
        fb_q  <= fc_q;
        fc_q  <= fb_q + fc_q;
        cnt_q <= cnt_q - 1'b1;
      end
      if (cmd_i.seq_init) begin
        k_q     <= '0;
        res_q   <= '0;
        ready_q <= 1'b1;
      end else if (cmd_i.out_load) begin
        k_q   <= is_last ? '0 : k_q + 1'b1;
        res_q <= is_last ? '0 : res_next;
      end else if (cmd_i.fib_load) begin
        ready_q <= 1'b0;
      end
    end
  end

  flp_div #(
    .FracBits (FracBits)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (cmd_i.div_sel_y ? res_q : k_q),
    .den_i   (fc_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.x_store) x_q <= WordW'(quo);
    if (cmd_i.y_store) y_q <= WordW'(quo);
    if (cmd_i.out_load) begin
      out_data_q <= {fc_q, y_q, res_q, x_q, k_q};
      out_last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.need_fib = restart_i | ~ready_q;
  assign sts_o.fib_done = (cnt_q == '0);
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> k_q < fc_q) else $error("point index beyond point count");
  a_res_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> res_q < fc_q) else $error("y residue beyond point count");
  a_step_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fib_step |-> cnt_q != '0) else $error("recurrence stepped past index");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> sts_o.out_free) else $error("output register overwritten");

endmodule

>>> rtl/flp_ctrl.sv
// controller state machine sequencing recurrence, divisions and output
`timescale 1ns / 1ps

module flp_ctrl import flp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  flp_sts_t sts_i,
  output flp_cmd_t cmd_o
);

  flp_state_e state_q, state_d;
  logic       accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = sts_i.need_fib ? ST_FIB : ST_XGO;
      end
      ST_FIB: begin
        if (sts_i.fib_done) state_d = ST_XGO;
      end
      ST_XGO:   state_d = ST_XWAIT;
      ST_XWAIT: begin
        if (sts_i.div_done) state_d = ST_YGO;
      end
      ST_YGO:   state_d = ST_YWAIT;
      ST_YWAIT: begin
        if (sts_i.div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.fib_load = accept && sts_i.need_fib;
      end
      ST_FIB: begin
        cmd_o.fib_step = ~sts_i.fib_done;
        cmd_o.seq_init = sts_i.fib_done;
      end
      ST_XGO:   cmd_o.div_start = 1'b1;
      ST_XWAIT: cmd_o.x_store = sts_i.div_done;
      ST_YGO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel_y = 1'b1;
      end
      ST_YWAIT: cmd_o.y_store = sts_i.div_done;
      ST_OUT:   cmd_o.out_load = sts_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_ready_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd_o.div_start && !cmd_o.out_load) else $error("busy while ready");
  a_fib_then_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.seq_init |=> state_q == ST_XGO) else $error("init not followed by division");
  a_load_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> state_q == ST_IDLE) else $error("output load left controller busy");

endmodule

>>> rtl/fibonacci_lattice_points.sv
// top level of the fibonacci lattice point generator
// the fibonacci recurrence is rerun ahead of the divisions on a restart or on the first request
//   after reset
// the shared radix-2 divider forms x and then y one quotient bit a cycle, and a new request is
//   taken only after the current point is loaded; a pending result does not stall the divisions
// reset: asynchronous active low, lattice index returns to 3 and the next request restarts
`timescale 1ns / 1ps

module fibonacci_lattice_points import flp_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [IdxW-1:0]    cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // restart
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [5*WordW-1:0] m_axis_tdata,   // point_index, x_frac, y_numerator, y_frac, point_count
  output logic               m_axis_tlast
);

  flp_cmd_t cmd;
  flp_sts_t sts;

  flp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  flp_dpath #(
    .FracBits (COORD_FRAC_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .restart_i   (s_axis_tdata[0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

>>> tb/lattice_point_checker.sv
// checker for the fibonacci lattice point generator: predicts every point and compares it
`timescale 1ns / 1ps

module lattice_point_checker import flp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [IdxW-1:0]    cfg_wdata_i,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // restart
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [5*WordW-1:0] m_axis_tdata,   // point_index, x_frac, y_numerator, y_frac, point_count
  input  logic               m_axis_tlast,
  output int unsigned        mismatch_count_o,
  output int unsigned        points_pending_o
);

  localparam int unsigned FirstStep = 4;

  typedef struct {
    logic [WordW-1:0] point_index;
    logic [WordW-1:0] x_frac;
    logic [WordW-1:0] y_numerator;
    logic [WordW-1:0] y_frac;
    logic [WordW-1:0] point_count;
    logic             last;
  } lattice_point_t;

  logic [IdxW-1:0]  lattice_idx = IdxMin;
  logic [WordW-1:0] set_size = '0;
  logic [WordW-1:0] stride = '0;
  logic [WordW-1:0] next_k = '0;
  logic [WordW-1:0] residue = '0;
  logic             set_valid = 1'b0;
  int unsigned      errors = 0;
  lattice_point_t   expected_points[$];
  lattice_point_t   got;
  lattice_point_t   want;
  lattice_point_t   fresh;

  function automatic logic [WordW-1:0] scaled_fraction(input logic [WordW-1:0] num,
                                                       input logic [WordW-1:0] den);
    logic [2*WordW-1:0] quotient;
    if (den == '0) return '0;
    quotient = {num, {WordW{1'b0}}} / {{WordW{1'b0}}, den};
    return quotient[WordW-1:0];
  endfunction

  task automatic advance_lattice(input logic restart, output lattice_point_t pt);
    logic [IdxW-1:0] idx;
    logic [63:0]     fa;
    logic [63:0]     fb;
    logic [63:0]     fc;
    logic [WordW:0]  sum;
    int unsigned     i;
    if (restart || !set_valid) begin
      idx = lattice_idx;
      if (idx < IdxMin) idx = IdxMin;
      if (idx > IdxMax) idx = IdxMax;
      fa = 64'(FibSeed);
      fb = 64'(FibSeed);
      fc = 64'(FibSeed) + 64'(FibSeed);
      for (i = FirstStep; i <= idx; i++) begin
        fa = fb;
        fb = fc;
        fc = fa + fb;
      end
      stride = fa[WordW-1:0];
      set_size = fc[WordW-1:0];
      next_k = '0;
      residue = '0;
      set_valid = 1'b1;
    end
    pt.point_index = next_k;
    pt.x_frac = scaled_fraction(next_k, set_size);
    pt.y_numerator = residue;
    pt.y_frac = scaled_fraction(residue, set_size);
    pt.point_count = set_size;
    pt.last = (next_k == set_size - 1'b1);
    if (pt.last) begin
      next_k = '0;
      residue = '0;
    end else begin
      next_k = next_k + 1'b1;
      sum = {1'b0, residue} + {1'b0, stride};
      if (sum >= {1'b0, set_size}) sum = sum - {1'b0, set_size};
      residue = sum[WordW-1:0];
    end
  endtask

  function automatic int unsigned field_differs(input string label,
                                                input logic [WordW-1:0] exp_val,
                                                input logic [WordW-1:0] act_val);
    if (exp_val === act_val) return 0;
    $display("%0t: %s expected %0d actual %0d", $time, label, exp_val, act_val);
    return 1;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      lattice_idx = IdxMin;
      set_valid = 1'b0;
      next_k = '0;
      residue = '0;
      set_size = '0;
      stride = '0;
      expected_points.delete();
    end else begin
      if (cfg_we_i) lattice_idx = cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        got.point_index = m_axis_tdata[0*WordW +: WordW];
        got.x_frac      = m_axis_tdata[1*WordW +: WordW];
        got.y_numerator = m_axis_tdata[2*WordW +: WordW];
        got.y_frac      = m_axis_tdata[3*WordW +: WordW];
        got.point_count = m_axis_tdata[4*WordW +: WordW];
        got.last        = m_axis_tlast;
        if (expected_points.size() == 0) begin
          $display("%0t: point expected none actual k %0d", $time, got.point_index);
          errors++;
        end else begin
          want = expected_points.pop_front();
          errors += field_differs("point_index", want.point_index, got.point_index);
          errors += field_differs("x_frac", want.x_frac, got.x_frac);
          errors += field_differs("y_numerator", want.y_numerator, got.y_numerator);
          errors += field_differs("y_frac", want.y_frac, got.y_frac);
          errors += field_differs("point_count", want.point_count, got.point_count);
          errors += field_differs("last", WordW'(want.last), WordW'(got.last));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_lattice(s_axis_tdata[0], fresh);
        expected_points.push_back(fresh);
      end
    end
    mismatch_count_o <= errors;
    points_pending_o <= expected_points.size();
  end

endmodule

>>> tb/fibonacci_lattice_points_test.sv
// testbench top for the fibonacci lattice point generator: stimulus, pacing and verdict
`timescale 1ns / 1ps

module fibonacci_lattice_points_test;
  import flp_pkg::*;

  localparam int unsigned CycleLimit     = 1_000_000;
  localparam int unsigned RandomRequests = 1450;
  localparam int unsigned SettleCycles   = 120;
  localparam logic        RestartReq     = 1'b1;
  localparam logic        NextReq        = 1'b0;

  typedef enum int unsigned {
    PaceFree,
    PaceSenderIdle,
    PaceReceiverStall,
    PaceBoth
  } pace_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [IdxW-1:0]    cfg_wdata_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [5*WordW-1:0] m_axis_tdata;
  logic               m_axis_tlast;

  int unsigned mismatch_count;
  int unsigned points_pending;
  int unsigned send_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned sent = 0;
  int unsigned phase = 0;
  int unsigned run_len;
  int unsigned j;

  fibonacci_lattice_points u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  lattice_point_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tlast     (m_axis_tlast),
    .mismatch_count_o (mismatch_count),
    .points_pending_o (points_pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("fibonacci_lattice_points: mismatch");
      $finish;
    end
  end

  task automatic set_pace(input pace_e pace);
    case (pace)
      PaceFree: begin
        send_idle_pct = 0;
        rx_stall_pct = 0;
      end
      PaceSenderIdle: begin
        send_idle_pct = 60;
        rx_stall_pct = 0;
      end
      PaceReceiverStall: begin
        send_idle_pct = 0;
        rx_stall_pct = 60;
      end
      default: begin
        send_idle_pct = 22;
        rx_stall_pct = 22;
      end
    endcase
  endtask

  // valid stays high across back-to-back transfers
  task automatic send_request(input logic restart);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, restart};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_points();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (points_pending != 0);
  endtask

  task automatic write_lattice_index(input logic [IdxW-1:0] value);
    drain_points();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly small lattices so that wrap-around comes often
  function automatic logic [IdxW-1:0] random_index();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return IdxW'($urandom_range(0, 12));
    if (r < 80) return IdxW'($urandom_range(40, 63));
    return IdxW'($urandom_range(0, 63));
  endfunction

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_pace(PaceFree);
    // first request after reset restarts on its own
    send_request(NextReq);
    send_request(NextReq);
    send_request(NextReq);
    send_request(RestartReq);
    // saturation above the largest index
    write_lattice_index(6'd63);
    send_request(RestartReq);
    send_request(NextReq);
    send_request(NextReq);
    write_lattice_index(IdxMax);
    send_request(RestartReq);
    send_request(NextReq);
    write_lattice_index(6'd48);
    send_request(RestartReq);
    // indices below the smallest act as the smallest
    write_lattice_index(6'd0);
    send_request(RestartReq);
    send_request(NextReq);
    send_request(NextReq);
    write_lattice_index(6'd1);
    send_request(RestartReq);
    write_lattice_index(6'd2);
    send_request(RestartReq);
    write_lattice_index(6'd5);
    send_request(RestartReq);
    repeat (5) send_request(NextReq);
    // new index waits for the next restart
    write_lattice_index(6'd4);
    send_request(NextReq);
    send_request(NextReq);
    send_request(RestartReq);

    while (sent < RandomRequests) begin
      set_pace(pace_e'(phase % 4));
      write_lattice_index(random_index());
      run_len = $urandom_range(15, 60);
      if ($urandom_range(99) < 85) begin
        send_request(RestartReq);
        sent++;
      end
      for (j = 0; j < run_len; j++) begin
        if ($urandom_range(99) < 3) send_request(RestartReq);
        else send_request(NextReq);
        sent++;
        if ($urandom_range(199) == 0) drain_points();
      end
      phase++;
    end

    drain_points();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("fibonacci_lattice_points: match");
    end else begin
      $display("fibonacci_lattice_points: mismatch");
    end
    $finish;
  end

endmodule
